// File: hw/rtl/cpu_alu_with_flags_assert.svh
// Assertion macros shared by the ALU checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define CALU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ALU check failed: same-cycle implication");

// Delayed implication: ante now, cons at a later edge.
`define CALU_ASSERT_LAT2(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("ALU check failed: result latency");

`endif

// File: hw/rtl/calu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package calu_pkg;

    // Operation codes
    localparam logic [4:0] OP_INC  = 5'd0;
    localparam logic [4:0] OP_DEC  = 5'd1;
    localparam logic [4:0] OP_ADD  = 5'd2;
    localparam logic [4:0] OP_ADC  = 5'd3;
    localparam logic [4:0] OP_SBC  = 5'd4;
    localparam logic [4:0] OP_CP   = 5'd5;
    localparam logic [4:0] OP_AND  = 5'd6;
    localparam logic [4:0] OP_XOR  = 5'd7;
    localparam logic [4:0] OP_OR   = 5'd8;
    localparam logic [4:0] OP_CPL  = 5'd9;
    localparam logic [4:0] OP_RLCA = 5'd10;
    localparam logic [4:0] OP_RRCA = 5'd11;
    localparam logic [4:0] OP_RLA  = 5'd12;
    localparam logic [4:0] OP_RRA  = 5'd13;
    localparam logic [4:0] OP_RLC  = 5'd14;
    localparam logic [4:0] OP_RRC  = 5'd15;
    localparam logic [4:0] OP_RL   = 5'd16;
    localparam logic [4:0] OP_RR   = 5'd17;
    localparam logic [4:0] OP_SLA  = 5'd18;
    localparam logic [4:0] OP_SRA  = 5'd19;
    localparam logic [4:0] OP_SWAP = 5'd20;
    localparam logic [4:0] OP_DAA  = 5'd21;
    localparam logic [4:0] OP_SRL  = 5'd22;
    localparam logic [4:0] OP_BIT  = 5'd23;

    // Write destinations
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ACC  = 2'd1;
    localparam logic [1:0] TGT_OPND = 2'd2;

    // Flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Decimal adjust constants
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_BYTE_LIM = 8'h99;
    localparam logic [3:0] DAA_NIB_LIM = 4'h9;

endpackage

`default_nettype wire

// File: hw/rtl/cpu_alu_with_flags.sv
`timescale 1ns / 1ps
`default_nettype none

// Eight-bit ALU with Z/N/H/C flags. A transaction is taken on every rising
// edge where start is high; busy is always low, so one operation per clock
// is sustained. The operands are registered on acceptance, the operation runs
// as a single pass through the ALU logic into the result register, and the
// result, new flags and write destination are on the ports once the result
// register has taken them, with done high for exactly that cycle; the
// receiver takes them at the rising edge that ends that cycle. The receiver
// cannot stall: each result must be captured in the cycle that done marks.
module cpu_alu_with_flags
    import calu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [4:0] opcode,
    input  wire logic [7:0] operand,
    input  wire logic [7:0] accumulator,
    input  wire logic [3:0] flags_in,
    input  wire logic [2:0] bit_index,
    output logic            done,
    output logic [7:0]      result,
    output logic [3:0]      flags_out,
    output logic [1:0]      write_target
);

    // Input stage
    logic       vld_reg;
    logic [4:0] op_reg;
    logic [7:0] opnd_reg;
    logic [7:0] acc_reg;
    logic [3:0] fl_reg;
    logic [2:0] bidx_reg;

    // Result stage
    logic       done_reg;
    logic [7:0] res_reg;
    logic [3:0] flg_reg;
    logic [1:0] tgt_reg;
    logic [7:0] res_next;
    logic [3:0] flg_next;
    logic [1:0] tgt_next;

    // Arithmetic helpers
    logic       cin;
    logic       cy_use;
    logic [8:0] sum9;
    logic [4:0] half_sum;
    logic [8:0] diff9;
    logic [4:0] half_diff;
    logic       daa_c;
    logic [7:0] daa_mid;
    logic [7:0] daa_res;

    assign busy = 1'b0;

    // Capture the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= opcode;
            opnd_reg <= operand;
            acc_reg  <= accumulator;
            fl_reg   <= flags_in;
            bidx_reg <= bit_index;
        end
    end

    // Adder and subtractor, shared by ADD/ADC and SBC/CP
    assign cin       = fl_reg[FLAG_C];
    assign cy_use    = (op_reg == OP_ADC || op_reg == OP_SBC) ? cin : 1'b0;
    assign sum9      = {1'b0, acc_reg} + {1'b0, opnd_reg} + {8'd0, cy_use};
    assign half_sum  = {1'b0, acc_reg[3:0]} + {1'b0, opnd_reg[3:0]} + {4'd0, cy_use};
    assign diff9     = {1'b0, acc_reg} - {1'b0, opnd_reg} - {8'd0, cy_use};
    assign half_diff = {1'b0, acc_reg[3:0]} - {1'b0, opnd_reg[3:0]} - {4'd0, cy_use};

    // Decimal adjust
    always_comb
    begin
        daa_c   = cin;
        daa_mid = acc_reg;
        daa_res = acc_reg;
        if (fl_reg[FLAG_N])
        begin
            daa_mid = fl_reg[FLAG_H] ? (acc_reg - DAA_LO_ADJ) : acc_reg;
            daa_res = cin ? (daa_mid - DAA_HI_ADJ) : daa_mid;
        end
        else
        begin
            if (cin || (acc_reg > DAA_BYTE_LIM))
            begin
                daa_mid = acc_reg + DAA_HI_ADJ;
                daa_c   = 1'b1;
            end
            if (fl_reg[FLAG_H] || (acc_reg[3:0] > DAA_NIB_LIM))
            begin
                daa_res = daa_mid + DAA_LO_ADJ;
            end
            else
            begin
                daa_res = daa_mid;
            end
        end
    end

    // Operation select; flags are {Z, N, H, C}
    always_comb
    begin
        res_next = acc_reg;
        flg_next = fl_reg;
        tgt_next = TGT_NONE;
        case (op_reg)
            OP_INC:
            begin
                res_next = opnd_reg + 8'd1;
                flg_next = {res_next == 8'd0, 1'b0, opnd_reg[3:0] == 4'hF, cin};
                tgt_next = TGT_OPND;
            end
            OP_DEC:
            begin
                res_next = opnd_reg - 8'd1;
                flg_next = {res_next == 8'd0, 1'b1, opnd_reg[3:0] == 4'h0, cin};
                tgt_next = TGT_OPND;
            end
            OP_ADD, OP_ADC:
            begin
                res_next = sum9[7:0];
                flg_next = {res_next == 8'd0, 1'b0, half_sum[4], sum9[8]};
                tgt_next = TGT_ACC;
            end
            OP_SBC, OP_CP:
            begin
                res_next = diff9[7:0];
                flg_next = {res_next == 8'd0, 1'b1, half_diff[4], diff9[8]};
                tgt_next = (op_reg == OP_SBC) ? TGT_ACC : TGT_NONE;
            end
            OP_AND:
            begin
                res_next = acc_reg & opnd_reg;
                flg_next = {res_next == 8'd0, 1'b0, 1'b1, 1'b0};
                tgt_next = TGT_ACC;
            end
            OP_XOR:
            begin
                res_next = acc_reg ^ opnd_reg;
                flg_next = {res_next == 8'd0, 3'b000};
                tgt_next = TGT_ACC;
            end
            OP_OR:
            begin
                res_next = acc_reg | opnd_reg;
                flg_next = {res_next == 8'd0, 3'b000};
                tgt_next = TGT_ACC;
            end
            OP_CPL:
            begin
                res_next = ~acc_reg;
                flg_next = {fl_reg[FLAG_Z], 1'b1, 1'b1, cin};
                tgt_next = TGT_ACC;
            end
            // accumulator rotates: Z, N and H always clear
            OP_RLCA:
            begin
                res_next = {acc_reg[6:0], acc_reg[7]};
                flg_next = {3'b000, acc_reg[7]};
                tgt_next = TGT_ACC;
            end
            OP_RRCA:
            begin
                res_next = {acc_reg[0], acc_reg[7:1]};
                flg_next = {3'b000, acc_reg[0]};
                tgt_next = TGT_ACC;
            end
            OP_RLA:
            begin
                res_next = {acc_reg[6:0], cin};
                flg_next = {3'b000, acc_reg[7]};
                tgt_next = TGT_ACC;
            end
            OP_RRA:
            begin
                res_next = {cin, acc_reg[7:1]};
                flg_next = {3'b000, acc_reg[0]};
                tgt_next = TGT_ACC;
            end
            // operand rotates and shifts
            OP_RLC:
            begin
                res_next = {opnd_reg[6:0], opnd_reg[7]};
                flg_next = {res_next == 8'd0, 2'b00, opnd_reg[7]};
                tgt_next = TGT_OPND;
            end
            OP_RRC:
            begin
                res_next = {opnd_reg[0], opnd_reg[7:1]};
                flg_next = {res_next == 8'd0, 2'b00, opnd_reg[0]};
                tgt_next = TGT_OPND;
            end
            OP_RL:
            begin
                res_next = {opnd_reg[6:0], cin};
                flg_next = {res_next == 8'd0, 2'b00, opnd_reg[7]};
                tgt_next = TGT_OPND;
            end
            OP_RR:
            begin
                res_next = {cin, opnd_reg[7:1]};
                flg_next = {res_next == 8'd0, 2'b00, opnd_reg[0]};
                tgt_next = TGT_OPND;
            end
            OP_SLA:
            begin
                res_next = {opnd_reg[6:0], 1'b0};
                flg_next = {res_next == 8'd0, 2'b00, opnd_reg[7]};
                tgt_next = TGT_OPND;
            end
            OP_SRA:
            begin
                res_next = {opnd_reg[7], opnd_reg[7:1]};
                flg_next = {res_next == 8'd0, 2'b00, opnd_reg[0]};
                tgt_next = TGT_OPND;
            end
            OP_SWAP:
            begin
                res_next = {opnd_reg[3:0], opnd_reg[7:4]};
                flg_next = {res_next == 8'd0, 3'b000};
                tgt_next = TGT_OPND;
            end
            OP_DAA:
            begin
                res_next = daa_res;
                flg_next = {res_next == 8'd0, fl_reg[FLAG_N], 1'b0, daa_c};
                tgt_next = TGT_ACC;
            end
            OP_SRL:
            begin
                res_next = {1'b0, opnd_reg[7:1]};
                flg_next = {res_next == 8'd0, 2'b00, opnd_reg[0]};
                tgt_next = TGT_OPND;
            end
            OP_BIT:
            begin
                res_next = 8'd0;
                flg_next = {~opnd_reg[bidx_reg], 1'b0, 1'b1, cin};
                tgt_next = TGT_NONE;
            end
            // unused codes pass the accumulator and flags through, no write
            default:
            begin
                res_next = acc_reg;
                flg_next = fl_reg;
                tgt_next = TGT_NONE;
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg)
        begin
            res_reg <= res_next;
            flg_reg <= flg_next;
            tgt_reg <= tgt_next;
        end
    end

    assign done         = done_reg;
    assign result       = res_reg;
    assign flags_out    = flg_reg;
    assign write_target = tgt_reg;

endmodule

`default_nettype wire

// File: hw/rtl/calu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "cpu_alu_with_flags_assert.svh"

module calu_checker
    import calu_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [4:0] opcode,
    input wire logic       done,
    input wire logic [7:0] result,
    input wire logic [1:0] write_target
);

    // The block never holds off a transaction
    `CALU_ASSERT_IMP(a_never_busy, 1'b1, !busy)

    // Every accepted transaction yields a result
    `CALU_ASSERT_LAT2(a_result_follows, start && !busy, done)

    // No result appears without a transaction behind it
    `CALU_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 2))

    // A bit test writes nothing and returns zero
    `CALU_ASSERT_IMP(a_bit_no_write, done && $past(start && !busy && opcode == OP_BIT, 2),
        result == 8'd0 && write_target == TGT_NONE)

    // Destination is always a legal code
    `CALU_ASSERT_IMP(a_target_legal, done, write_target != 2'd3)

endmodule

bind cpu_alu_with_flags calu_checker u_calu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .done         (done),
    .result       (result),
    .write_target (write_target)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import calu_pkg::*;

    localparam int CYCLE_LIMIT   = 50000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 100;

    // Codes beyond BIT: the ALU passes the accumulator and flags through
    localparam logic [4:0] OP_SPARE_LO = 5'd24;
    localparam logic [4:0] OP_SPARE_HI = 5'd31;

    // Single flag masks
    localparam logic [3:0] F_Z = 4'b0001 << FLAG_Z;
    localparam logic [3:0] F_N = 4'b0001 << FLAG_N;
    localparam logic [3:0] F_H = 4'b0001 << FLAG_H;
    localparam logic [3:0] F_C = 4'b0001 << FLAG_C;

    typedef struct packed {
        logic [4:0] op;
        logic [7:0] value;
        logic [3:0] flags;
        logic [1:0] target;
    } alu_outcome_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [4:0] opcode;
    logic [7:0] operand;
    logic [7:0] accumulator;
    logic [3:0] flags_in;
    logic [2:0] bit_index;
    logic       done;
    logic [7:0] result;
    logic [3:0] flags_out;
    logic [1:0] write_target;

    alu_outcome_t pending_results[$];
    int           error_count;
    int           cycle_count;
    bit           gaps_enabled;

    cpu_alu_with_flags DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .operand      (operand),
        .accumulator  (accumulator),
        .flags_in     (flags_in),
        .bit_index    (bit_index),
        .done         (done),
        .result       (result),
        .flags_out    (flags_out),
        .write_target (write_target)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected value, flags and destination for one operation
    function automatic alu_outcome_t predict_alu(input logic [4:0] op, input logic [7:0] v,
                                                 input logic [7:0] a, input logic [3:0] fi,
                                                 input logic [2:0] bi);
        alu_outcome_t o;
        logic [7:0]   r;
        logic [3:0]   f;
        logic [1:0]   tgt;
        logic [8:0]   wide;
        logic [4:0]   half;
        logic         cin;
        logic         cy_used;
        logic         cy;
        logic         zero_tracks;
        cin         = fi[FLAG_C];
        r           = a;
        f           = 4'b0000;
        tgt         = TGT_NONE;
        zero_tracks = 1'b1;
        case (op)
            OP_INC:
            begin
                r         = v + 8'd1;
                f[FLAG_H] = (v[3:0] == 4'hF);
                f[FLAG_C] = cin;
                tgt       = TGT_OPND;
            end
            OP_DEC:
            begin
                r         = v - 8'd1;
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = (v[3:0] == 4'h0);
                f[FLAG_C] = cin;
                tgt       = TGT_OPND;
            end
            OP_ADD, OP_ADC:
            begin
                cy_used   = (op == OP_ADC) ? cin : 1'b0;
                wide      = {1'b0, a} + {1'b0, v} + {8'b0, cy_used};
                half      = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, cy_used};
                r         = wide[7:0];
                f[FLAG_H] = half[4];
                f[FLAG_C] = wide[8];
                tgt       = TGT_ACC;
            end
            OP_SBC, OP_CP:
            begin
                // a borrow shows up as the ninth (or fifth) bit of the wrapped difference
                cy_used   = (op == OP_SBC) ? cin : 1'b0;
                wide      = {1'b0, a} - {1'b0, v} - {8'b0, cy_used};
                half      = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, cy_used};
                r         = wide[7:0];
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = half[4];
                f[FLAG_C] = wide[8];
                tgt       = (op == OP_SBC) ? TGT_ACC : TGT_NONE;
            end
            OP_AND:
            begin
                r         = a & v;
                f[FLAG_H] = 1'b1;
                tgt       = TGT_ACC;
            end
            OP_XOR:
            begin
                r   = a ^ v;
                tgt = TGT_ACC;
            end
            OP_OR:
            begin
                r   = a | v;
                tgt = TGT_ACC;
            end
            OP_CPL:
            begin
                r           = ~a;
                f           = fi & (F_Z | F_C);
                f[FLAG_N]   = 1'b1;
                f[FLAG_H]   = 1'b1;
                tgt         = TGT_ACC;
                zero_tracks = 1'b0;
            end
            // Accumulator rotates always clear Z
            OP_RLCA:
            begin
                r           = {a[6:0], a[7]};
                f[FLAG_C]   = a[7];
                tgt         = TGT_ACC;
                zero_tracks = 1'b0;
            end
            OP_RRCA:
            begin
                r           = {a[0], a[7:1]};
                f[FLAG_C]   = a[0];
                tgt         = TGT_ACC;
                zero_tracks = 1'b0;
            end
            OP_RLA:
            begin
                r           = {a[6:0], cin};
                f[FLAG_C]   = a[7];
                tgt         = TGT_ACC;
                zero_tracks = 1'b0;
            end
            OP_RRA:
            begin
                r           = {cin, a[7:1]};
                f[FLAG_C]   = a[0];
                tgt         = TGT_ACC;
                zero_tracks = 1'b0;
            end
            OP_RLC:
            begin
                r         = {v[6:0], v[7]};
                f[FLAG_C] = v[7];
                tgt       = TGT_OPND;
            end
            OP_RRC:
            begin
                r         = {v[0], v[7:1]};
                f[FLAG_C] = v[0];
                tgt       = TGT_OPND;
            end
            OP_RL:
            begin
                r         = {v[6:0], cin};
                f[FLAG_C] = v[7];
                tgt       = TGT_OPND;
            end
            OP_RR:
            begin
                r         = {cin, v[7:1]};
                f[FLAG_C] = v[0];
                tgt       = TGT_OPND;
            end
            OP_SLA:
            begin
                r         = {v[6:0], 1'b0};
                f[FLAG_C] = v[7];
                tgt       = TGT_OPND;
            end
            OP_SRA:
            begin
                r         = {v[7], v[7:1]};
                f[FLAG_C] = v[0];
                tgt       = TGT_OPND;
            end
            OP_SWAP:
            begin
                r   = {v[3:0], v[7:4]};
                tgt = TGT_OPND;
            end
            OP_SRL:
            begin
                r         = {1'b0, v[7:1]};
                f[FLAG_C] = v[0];
                tgt       = TGT_OPND;
            end
            OP_DAA:
            begin
                cy = cin;
                if (fi[FLAG_N])
                begin
                    if (fi[FLAG_H])
                        r = r - DAA_LO_ADJ;
                    if (cy)
                        r = r - DAA_HI_ADJ;
                end
                else
                begin
                    if (cy || r > DAA_BYTE_LIM)
                    begin
                        r  = r + DAA_HI_ADJ;
                        cy = 1'b1;
                    end
                    if (fi[FLAG_H] || a[3:0] > DAA_NIB_LIM)
                        r = r + DAA_LO_ADJ;
                end
                f[FLAG_N] = fi[FLAG_N];
                f[FLAG_C] = cy;
                tgt       = TGT_ACC;
            end
            OP_BIT:
            begin
                r           = 8'h00;
                f[FLAG_Z]   = ~v[bi];
                f[FLAG_H]   = 1'b1;
                f[FLAG_C]   = cin;
                zero_tracks = 1'b0;
            end
            default:
            begin
                f           = fi;
                zero_tracks = 1'b0;
            end
        endcase
        if (zero_tracks)
            f[FLAG_Z] = (r == 8'h00);
        o.op     = op;
        o.value  = r;
        o.flags  = f;
        o.target = tgt;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [4:0] op,
                                   input int got, input int want);
        // keep the log readable when something breaks everywhere
        if (error_count < PRINT_LIMIT)
            $display("tb: mismatch on %s, op %0d: got %0h, want %0h", what, op, got, want);
        error_count++;
    endtask

    // Drive one transaction and record what it should produce once accepted
    task automatic issue_op(input logic [4:0] op, input logic [7:0] v, input logic [7:0] a,
                            input logic [3:0] fi, input logic [2:0] bi);
        if (gaps_enabled)
            while ($urandom_range(99) < 15)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start       <= 1'b1;
        opcode      <= op;
        operand     <= v;
        accumulator <= a;
        flags_in    <= fi;
        bit_index   <= bi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_alu(op, v, a, fi, bi));
    endtask

    // Byte values with the corners weighted up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h0F;
            3:       return 8'h99;
            4:       return 8'h9A;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [4:0] pick_op();
        if ($urandom_range(19) == 0)
            return 5'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        return 5'($urandom_range(OP_BIT, OP_INC));
    endfunction

    // Every defined code once, alternating all-ones and all-zeros inputs, then two spare codes
    task automatic test_every_operation();
        for (int k = OP_INC; k <= OP_BIT; k++)
        begin
            if (k % 2 == 0)
                issue_op(5'(k), 8'hFF, 8'hFF, 4'hF, 3'd7);
            else
                issue_op(5'(k), 8'h00, 8'h00, 4'h0, 3'd0);
        end
        issue_op(OP_SPARE_LO, 8'h5A, 8'hA5, F_Z | F_H, 3'd2);
        issue_op(OP_SPARE_HI, 8'hFF, 8'h3C, F_N | F_C, 3'd5);
    endtask

    // Decimal adjust: over 0x99 after an add, carry set, after a subtraction, wrap
    task automatic test_decimal_adjust();
        issue_op(OP_DAA, 8'h00, 8'h9A, 4'h0, 3'd0);
        issue_op(OP_DAA, 8'h00, 8'h45, F_C, 3'd0);
        issue_op(OP_DAA, 8'h00, 8'h0F, F_N | F_H, 3'd0);
        issue_op(OP_DAA, 8'h00, 8'h00, F_N | F_H | F_C, 3'd0);
    endtask

    task automatic test_random_ops(input int count, input bit with_gaps);
        gaps_enabled = with_gaps;
        repeat (count)
            issue_op(pick_op(), pick_byte(), pick_byte(), 4'($urandom_range(15)),
                     3'($urandom_range(7)));
    endtask

    // Result checker: done marks the one cycle each result is valid
    always @(posedge clk)
    begin : check_results
        alu_outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 5'd0, int'(result), 0);
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.value)
                    report_mismatch("result", want.op, int'(result), int'(want.value));
                if (flags_out !== want.flags)
                    report_mismatch("flags_out", want.op, int'(flags_out),
                                    int'(want.flags));
                if (write_target !== want.target)
                    report_mismatch("write_target", want.op, int'(write_target),
                                    int'(want.target));
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    // Test sequence
    initial
    begin
        error_count  = 0;
        gaps_enabled = 1'b1;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        opcode      <= OP_INC;
        operand     <= 8'h00;
        accumulator <= 8'h00;
        flags_in    <= 4'h0;
        bit_index   <= 3'd0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_every_operation();
        test_decimal_adjust();
        test_random_ops(250, 1'b0);
        test_random_ops(550, 1'b1);
        start <= 1'b0;

        // Drain outstanding results, then give the pipeline time to misbehave
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
